[src/sm4_pkg.sv]
// Shared types, constants and round functions for the SM4 core.
package sm4_pkg;

  localparam int unsigned NumRounds = 32;
  localparam int unsigned RkAw      = $clog2(NumRounds);

  typedef enum logic [1:0] {
    OP_KEY  = 2'd0,
    OP_ECB  = 2'd1,
    OP_CTR  = 2'd2,
    OP_RSVD = 2'd3
  } op_t;

  localparam logic CFG_IV_UPPER = 1'b0;
  localparam logic CFG_IV_LOWER = 1'b1;

  // controller -> datapath
  typedef struct packed {
    logic load;     // capture block / iv into round state
    logic is_ctr;   // loaded block is a counter block
    logic reload;   // counter reloaded from iv before this block
    logic round;    // apply one round
    logic finish;   // form result into output register
  } sm4_cmd_t;

  function automatic logic [7:0] sbox(input logic [7:0] a);
    logic [7:0] t [256];
    t = '{
      8'hd6,8'h90,8'he9,8'hfe,8'hcc,8'he1,8'h3d,8'hb7,8'h16,8'hb6,8'h14,8'hc2,8'h28,8'hfb,8'h2c,8'h05,
      8'h2b,8'h67,8'h9a,8'h76,8'h2a,8'hbe,8'h04,8'hc3,8'haa,8'h44,8'h13,8'h26,8'h49,8'h86,8'h06,8'h99,
      8'h9c,8'h42,8'h50,8'hf4,8'h91,8'hef,8'h98,8'h7a,8'h33,8'h54,8'h0b,8'h43,8'hed,8'hcf,8'hac,8'h62,
      8'he4,8'hb3,8'h1c,8'ha9,8'hc9,8'h08,8'he8,8'h95,8'h80,8'hdf,8'h94,8'hfa,8'h75,8'h8f,8'h3f,8'ha6,
      8'h47,8'h07,8'ha7,8'hfc,8'hf3,8'h73,8'h17,8'hba,8'h83,8'h59,8'h3c,8'h19,8'he6,8'h85,8'h4f,8'ha8,
      8'h68,8'h6b,8'h81,8'hb2,8'h71,8'h64,8'hda,8'h8b,8'hf8,8'heb,8'h0f,8'h4b,8'h70,8'h56,8'h9d,8'h35,
      8'h1e,8'h24,8'h0e,8'h5e,8'h63,8'h58,8'hd1,8'ha2,8'h25,8'h22,8'h7c,8'h3b,8'h01,8'h21,8'h78,8'h87,
      8'hd4,8'h00,8'h46,8'h57,8'h9f,8'hd3,8'h27,8'h52,8'h4c,8'h36,8'h02,8'he7,8'ha0,8'hc4,8'hc8,8'h9e,
      8'hea,8'hbf,8'h8a,8'hd2,8'h40,8'hc7,8'h38,8'hb5,8'ha3,8'hf7,8'hf2,8'hce,8'hf9,8'h61,8'h15,8'ha1,
      8'he0,8'hae,8'h5d,8'ha4,8'h9b,8'h34,8'h1a,8'h55,8'had,8'h93,8'h32,8'h30,8'hf5,8'h8c,8'hb1,8'he3,
      8'h1d,8'hf6,8'he2,8'h2e,8'h82,8'h66,8'hca,8'h60,8'hc0,8'h29,8'h23,8'hab,8'h0d,8'h53,8'h4e,8'h6f,
      8'hd5,8'hdb,8'h37,8'h45,8'hde,8'hfd,8'h8e,8'h2f,8'h03,8'hff,8'h6a,8'h72,8'h6d,8'h6c,8'h5b,8'h51,
      8'h8d,8'h1b,8'haf,8'h92,8'hbb,8'hdd,8'hbc,8'h7f,8'h11,8'hd9,8'h5c,8'h41,8'h1f,8'h10,8'h5a,8'hd8,
      8'h0a,8'hc1,8'h31,8'h88,8'ha5,8'hcd,8'h7b,8'hbd,8'h2d,8'h74,8'hd0,8'h12,8'hb8,8'he5,8'hb4,8'hb0,
      8'h89,8'h69,8'h97,8'h4a,8'h0c,8'h96,8'h77,8'h7e,8'h65,8'hb9,8'hf1,8'h09,8'hc5,8'h6e,8'hc6,8'h84,
      8'h18,8'hf0,8'h7d,8'hec,8'h3a,8'hdc,8'h4d,8'h20,8'h79,8'hee,8'h5f,8'h3e,8'hd7,8'hcb,8'h39,8'h48
    };
    return t[a];
  endfunction

  function automatic logic [31:0] rotl(input logic [31:0] v, input int unsigned n);
    return (v << n) | (v >> (32 - n));
  endfunction

  function automatic logic [31:0] round_t(input logic [31:0] a);
    logic [31:0] b;
    b = {sbox(a[31:24]), sbox(a[23:16]), sbox(a[15:8]), sbox(a[7:0])};
    return b ^ rotl(b, 2) ^ rotl(b, 10) ^ rotl(b, 18) ^ rotl(b, 24);
  endfunction

endpackage

[src/sm4_encrypt_ecb_ctr_core.sv]
// Top level of the SM4 block encryption core with single-block and CTR32 modes.
//   Port group   Direction   Handshake        Contents
//   in_*         input       valid / stall    op, key index/word, block, start
//   out_*        output      valid / stall    encrypted block
//   cfg_*        input       write enable     iv_upper (0), iv_lower (1)
// A key load writes one round key word and leaves the core idle. A block holds
// the input from acceptance until its hand-off: the accepting cycle loads the
// round state, 32 rounds follow through a single round unit reading one stored
// round key a cycle, then one hand-off into the output register. A result waiting
// in the output register does not hold up the next block until that block
// finishes.
// Reset clears control and the counter; round keys are undefined until loaded.
module sm4_encrypt_ecb_ctr_core
  import sm4_pkg::*;
#(
  parameter int unsigned NRounds = NumRounds
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [63:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_op,
  input  logic [4:0]  in_key_index,
  input  logic [31:0] in_key_word,
  input  logic [63:0] in_block_upper,
  input  logic [63:0] in_block_lower,
  input  logic        in_start_req,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] out_result_upper,
  output logic [63:0] out_result_lower
);

  sm4_cmd_t cmd;
  logic [$clog2(NRounds)-1:0] round_idx;
  logic key_we;
  logic [63:0] iv_upper_r, iv_lower_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      iv_upper_r <= '0;
      iv_lower_r <= '0;
    end else if (cfg_we) begin
      if (cfg_index == CFG_IV_UPPER) iv_upper_r <= cfg_wdata;
      if (cfg_index == CFG_IV_LOWER) iv_lower_r <= cfg_wdata;
    end
  end

  sm4_ctrl #(.NRounds(NRounds)) u_ctrl (
    .clk, .rst_n, .in_valid, .in_stall, .in_op, .in_start_req,
    .out_valid, .out_stall, .round_idx, .key_we, .cmd
  );

  sm4_dpath #(.NRounds(NRounds)) u_dpath (
    .clk, .rst_n, .cmd, .round_idx, .key_we,
    .key_index   (in_key_index[$clog2(NRounds)-1:0]),
    .key_word    (in_key_word),
    .block_upper (in_block_upper),
    .block_lower (in_block_lower),
    .iv_upper    (iv_upper_r),
    .iv_lower    (iv_lower_r),
    .result_upper(out_result_upper),
    .result_lower(out_result_lower)
  );

endmodule

[src/sm4_ctrl.sv]
// Sequencer for the SM4 core: accepts requests, runs rounds, hands off results.
module sm4_ctrl
  import sm4_pkg::*;
#(
  parameter int unsigned NRounds = NumRounds
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  logic [1:0] in_op,
  input  logic     in_start_req,
  output logic     out_valid,
  input  logic     out_stall,
  output logic [$clog2(NRounds)-1:0] round_idx,
  output logic     key_we,
  output sm4_cmd_t cmd
);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_RUN   = 3'b010,
    ST_DONE  = 3'b100
  } state_t;

  state_t state_r, state_nxt;
  logic [$clog2(NRounds)-1:0] cnt_r, cnt_nxt;
  logic out_valid_r, out_valid_nxt;
  logic accept;

  // a finished result may sit in the output register while the next runs;
  // only the hand-off waits for it to drain
  assign in_stall  = (state_r != ST_IDLE);
  assign accept    = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign round_idx = cnt_r;
  assign key_we    = accept && (in_op == OP_KEY);

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r && out_stall;
    cmd           = '0;
    cmd.is_ctr    = (in_op == OP_CTR);
    cmd.reload    = in_start_req;
    unique case (state_r)
      ST_IDLE: begin
        if (accept && (in_op == OP_ECB || in_op == OP_CTR)) begin
          cmd.load  = 1'b1;
          cnt_nxt   = '0;
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        cmd.round = 1'b1;
        cnt_nxt   = cnt_r + 1'b1;
        if (cnt_r == ($clog2(NRounds))'(NRounds - 1)) state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          cmd.finish    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

[src/sm4_dpath.sv]
// SM4 datapath: round key store, counter, round state and output register.
module sm4_dpath
  import sm4_pkg::*;
#(
  parameter int unsigned NRounds = NumRounds
) (
  input  logic         clk,
  input  logic         rst_n,
  input  sm4_cmd_t     cmd,
  input  logic [$clog2(NRounds)-1:0] round_idx,
  input  logic         key_we,
  input  logic [$clog2(NRounds)-1:0] key_index,
  input  logic [31:0]  key_word,
  input  logic [63:0]  block_upper,
  input  logic [63:0]  block_lower,
  input  logic [63:0]  iv_upper,
  input  logic [63:0]  iv_lower,
  output logic [63:0]  result_upper,
  output logic [63:0]  result_lower
);

  logic [31:0] rk_mem [NRounds];
  logic [31:0] rk_q;
  logic [31:0] ctr_r, ctr_nxt;
  logic [31:0] w_r [4];
  logic [127:0] data_r;
  logic        ctr_mode_r;
  logic [63:0] res_hi_r, res_lo_r;
  logic [31:0] nw;
  logic [$clog2(NRounds)-1:0] rd_addr;

  // key read is registered: the next round's key is fetched in the cycle before its use
  assign rd_addr = cmd.load ? '0 : round_idx + 1'b1;

  always_ff @(posedge clk) begin
    if (key_we) rk_mem[key_index] <= key_word;
    rk_q <= rk_mem[rd_addr];
  end

  always_comb begin
    ctr_nxt = ctr_r;
    if (cmd.load && cmd.is_ctr) begin
      ctr_nxt = (cmd.reload ? iv_lower[31:0] : ctr_r) + 32'd1;
    end
  end

  assign nw = w_r[0] ^ round_t(w_r[1] ^ w_r[2] ^ w_r[3] ^ rk_q);

  always_ff @(posedge clk) begin
    if (!rst_n) ctr_r <= '0;
    else        ctr_r <= ctr_nxt;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      ctr_mode_r <= cmd.is_ctr;
      data_r     <= {block_upper, block_lower};
      if (cmd.is_ctr) begin
        w_r[0] <= iv_upper[63:32];
        w_r[1] <= iv_upper[31:0];
        w_r[2] <= iv_lower[63:32];
        w_r[3] <= cmd.reload ? iv_lower[31:0] : ctr_r;
      end else begin
        w_r[0] <= block_upper[63:32];
        w_r[1] <= block_upper[31:0];
        w_r[2] <= block_lower[63:32];
        w_r[3] <= block_lower[31:0];
      end
    end else if (cmd.round) begin
      w_r[0] <= w_r[1];
      w_r[1] <= w_r[2];
      w_r[2] <= w_r[3];
      w_r[3] <= nw;
    end
    if (cmd.finish) begin
      res_hi_r <= {w_r[3], w_r[2]} ^ (ctr_mode_r ? data_r[127:64] : 64'd0);
      res_lo_r <= {w_r[1], w_r[0]} ^ (ctr_mode_r ? data_r[63:0] : 64'd0);
    end
  end

  assign result_upper = res_hi_r;
  assign result_lower = res_lo_r;

endmodule
